@@ sv/perspective_point_projector_macros.svh @@
// Assertion macros shared by the projector checker.
`ifndef PERSPECTIVE_POINT_PROJECTOR_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECTOR_MACROS_SVH

// Asserts an implication on every rising clock edge outside reset.
`define PPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Asserts a property that also holds during reset.
`define PPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/ppp_pkg.sv @@
// Package with constants, types and helpers of the point projector.
package ppp_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned RowW = 48;
  localparam int unsigned DotW = 32;
  localparam int unsigned DepthShift = 15;
  localparam int unsigned AxisShift = 7;
  localparam int unsigned AxisW = DotW - AxisShift;
  localparam int unsigned DepthW = DotW - DepthShift;
  localparam logic [CoordW-1:0] CenterX = 16'd160;
  localparam logic [CoordW-1:0] CenterY = 16'd100;

  localparam logic [2:0] RegCamX = 3'd0;
  localparam logic [2:0] RegCamY = 3'd1;
  localparam logic [2:0] RegCamZ = 3'd2;
  localparam logic [2:0] RegRowX = 3'd3;
  localparam logic [2:0] RegRowY = 3'd4;
  localparam logic [2:0] RegRowD = 3'd5;

  typedef struct packed {
    logic signed [AxisW-1:0]  ax;
    logic signed [AxisW-1:0]  ay;
    logic        [DepthW-1:0] depth;
  } proj_t;

  typedef struct packed {
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [CoordW-1:0] pd;
  } result_t;

endpackage

@@ sv/ppp_dot.sv @@
// Pipelined three-term dot product: camera offset, multiply, then sum.
module ppp_dot
  import ppp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [CoordW-1:0]        px_i,
  input  logic [CoordW-1:0]        py_i,
  input  logic [CoordW-1:0]        pz_i,
  input  logic [CoordW-1:0]        cam_x_i,
  input  logic [CoordW-1:0]        cam_y_i,
  input  logic [CoordW-1:0]        cam_z_i,
  input  logic [RowW-1:0]          row_x_i,
  input  logic [RowW-1:0]          row_y_i,
  input  logic [RowW-1:0]          row_d_i,
  output logic                     valid_o,
  output logic                     keep_o,
  output proj_t                    proj_o
);

  logic                    v1_q, v2_q, v3_q;
  logic signed [CoordW-1:0] x_q, y_q, z_q;
  logic signed [DotW-1:0]   p_q [9];
  logic [DotW-1:0]          sx_q, sy_q, sd_q;
  logic signed [DotW-1:0]   sd_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= px_i - cam_x_i;
      y_q <= py_i - cam_y_i;
      z_q <= pz_i - cam_z_i;
      p_q[0] <= DotW'(x_q * $signed(row_x_i[15:0]));
      p_q[1] <= DotW'(y_q * $signed(row_x_i[31:16]));
      p_q[2] <= DotW'(z_q * $signed(row_x_i[47:32]));
      p_q[3] <= DotW'(x_q * $signed(row_y_i[15:0]));
      p_q[4] <= DotW'(y_q * $signed(row_y_i[31:16]));
      p_q[5] <= DotW'(z_q * $signed(row_y_i[47:32]));
      p_q[6] <= DotW'(x_q * $signed(row_d_i[15:0]));
      p_q[7] <= DotW'(y_q * $signed(row_d_i[31:16]));
      p_q[8] <= DotW'(z_q * $signed(row_d_i[47:32]));
      sx_q <= p_q[0] + p_q[1] + p_q[2];
      sy_q <= p_q[3] + p_q[4] + p_q[5];
      sd_q <= p_q[6] + p_q[7] + p_q[8];
    end
  end

  assign sd_s = $signed(sd_q) >>> DepthShift;
  assign valid_o = v3_q;
  assign keep_o = (sd_s > 0);
  assign proj_o.ax = AxisW'($signed(sx_q) >>> AxisShift);
  assign proj_o.ay = AxisW'($signed(sy_q) >>> AxisShift);
  assign proj_o.depth = DepthW'(sd_s);

endmodule

@@ sv/ppp_div.sv @@
// Pipelined restoring divider for both screen axes, one quotient bit per stage.
module ppp_div
  import ppp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  proj_t   proj_i,
  output logic    valid_o,
  output result_t res_o
);

  localparam int unsigned Steps = AxisW;

  logic [Steps:0]        v_q;
  logic [AxisW-1:0]      qx_q [Steps+1];
  logic [AxisW-1:0]      qy_q [Steps+1];
  logic [DepthW-1:0]     rx_q [Steps+1];
  logic [DepthW-1:0]     ry_q [Steps+1];
  logic [DepthW-1:0]     d_q  [Steps+1];
  logic [Steps:0]        nx_q, ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q[0] <= proj_i.ax[AxisW-1];
      ny_q[0] <= proj_i.ay[AxisW-1];
      qx_q[0] <= proj_i.ax[AxisW-1] ? AxisW'(-proj_i.ax) : proj_i.ax;
      qy_q[0] <= proj_i.ay[AxisW-1] ? AxisW'(-proj_i.ay) : proj_i.ay;
      rx_q[0] <= '0;
      ry_q[0] <= '0;
      d_q[0]  <= proj_i.depth;
      for (int s = 0; s < Steps; s++) begin
        logic [DepthW:0] tx, ty;
        tx = {rx_q[s], qx_q[s][AxisW-1]};
        ty = {ry_q[s], qy_q[s][AxisW-1]};
        if (tx >= {1'b0, d_q[s]}) begin
          rx_q[s+1] <= DepthW'(tx - {1'b0, d_q[s]});
          qx_q[s+1] <= {qx_q[s][AxisW-2:0], 1'b1};
        end else begin
          rx_q[s+1] <= DepthW'(tx);
          qx_q[s+1] <= {qx_q[s][AxisW-2:0], 1'b0};
        end
        if (ty >= {1'b0, d_q[s]}) begin
          ry_q[s+1] <= DepthW'(ty - {1'b0, d_q[s]});
          qy_q[s+1] <= {qy_q[s][AxisW-2:0], 1'b1};
        end else begin
          ry_q[s+1] <= DepthW'(ty);
          qy_q[s+1] <= {qy_q[s][AxisW-2:0], 1'b0};
        end
        d_q[s+1]  <= d_q[s];
        nx_q[s+1] <= nx_q[s];
        ny_q[s+1] <= ny_q[s];
      end
    end
  end

  logic [AxisW-1:0] fx, fy;
  assign fx = nx_q[Steps] ? AxisW'(-qx_q[Steps]) : qx_q[Steps];
  assign fy = ny_q[Steps] ? AxisW'(-qy_q[Steps]) : qy_q[Steps];
  assign valid_o = v_q[Steps];
  assign res_o.sx = fx[CoordW-1:0] + CenterX;
  assign res_o.sy = fy[CoordW-1:0] + CenterY;
  assign res_o.pd = d_q[Steps][CoordW-1:0];

endmodule

@@ sv/perspective_point_projector.sv @@
// Top level of the perspective point projector.
// Pipeline: 3 dot-product stages, 26 divider stages and one output register.
// Throughput: one point per cycle; points with depth not above zero leave no transfer.
// The whole pipeline advances together and holds while a waiting result is not taken.
// Reset clears all valid bits and sets every configuration register to zero.
module perspective_point_projector
  import ppp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // point_x, point_y, point_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // screen_x, screen_y, point_depth
);

  logic [CoordW-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [RowW-1:0]   row_x_q, row_y_q, row_d_q;
  logic [2:0]        ridx;
  logic              en, dv, kv, ov;
  proj_t             proj;
  result_t           res, out_q;
  logic              out_v_q;

  assign pready = 1'b1;
  assign ridx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      row_x_q <= '0;
      row_y_q <= '0;
      row_d_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        RegCamX: cam_x_q <= pwdata[CoordW-1:0];
        RegCamY: cam_y_q <= pwdata[CoordW-1:0];
        RegCamZ: cam_z_q <= pwdata[CoordW-1:0];
        RegRowX: row_x_q <= pwdata[RowW-1:0];
        RegRowY: row_y_q <= pwdata[RowW-1:0];
        RegRowD: row_d_q <= pwdata[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegCamX: prdata = 64'(cam_x_q);
      RegCamY: prdata = 64'(cam_y_q);
      RegCamZ: prdata = 64'(cam_z_q);
      RegRowX: prdata = 64'(row_x_q);
      RegRowY: prdata = 64'(row_y_q);
      RegRowD: prdata = 64'(row_d_q);
      default: prdata = '0;
    endcase
  end

  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  ppp_dot u_dot (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .px_i(s_axis_tdata[15:0]), .py_i(s_axis_tdata[31:16]), .pz_i(s_axis_tdata[47:32]),
    .cam_x_i(cam_x_q), .cam_y_i(cam_y_q), .cam_z_i(cam_z_q),
    .row_x_i(row_x_q), .row_y_i(row_y_q), .row_d_i(row_d_q),
    .valid_o(dv), .keep_o(kv), .proj_o(proj)
  );

  ppp_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv && kv), .proj_i(proj),
    .valid_o(ov), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= ov;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {out_q.pd, out_q.sy, out_q.sx};

endmodule

@@ sv/ppp_checker.sv @@
// Port-level checker for the projector, bound to the top level.
`include "perspective_point_projector_macros.svh"
module ppp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        pready
);

  logic out_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `PPP_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "held result changed")
  `PPP_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
  `PPP_ASSERT(a_ready_stall, out_stall |-> !s_axis_tready, "input taken during stall")
  `PPP_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind perspective_point_projector ppp_checker u_ppp_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the perspective point projector.
`timescale 1ns / 1ps

module testbench
  import ppp_pkg::*;
;

  typedef struct packed {
    logic [15:0] pz;
    logic [15:0] py;
    logic [15:0] px;
  } point_t;

  typedef struct packed {
    logic [15:0] pd;
    logic [15:0] sy;
    logic [15:0] sx;
  } screen_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  perspective_point_projector u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0] cam_x, cam_y, cam_z;
  logic [47:0] row_x, row_y, row_d;
  point_t      point_q[$];
  screen_t     screen_q[$];
  int          src_idle = 0;
  int          sink_stall = 0;
  int          hold_cycles = 0;
  int          errors = 0;
  int          n_points = 0;
  int          n_screens = 0;
  int          n_culled = 0;

  function automatic logic signed [31:0] row_dot(logic [47:0] row, logic signed [15:0] x,
                                                 logic signed [15:0] y, logic signed [15:0] z);
    logic signed [31:0] a, b, c;
    a = 32'(x) * 32'($signed(row[15:0]));
    b = 32'(y) * 32'($signed(row[31:16]));
    c = 32'(z) * 32'($signed(row[47:32]));
    return a + b + c;
  endfunction

  task automatic project_point(point_t p);
    logic signed [15:0] x, y, z;
    logic signed [31:0] dep, ax, ay, qx, qy;
    screen_t s;
    x = p.px - cam_x;
    y = p.py - cam_y;
    z = p.pz - cam_z;
    dep = row_dot(row_d, x, y, z) >>> 15;
    if (dep <= 0) begin
      n_culled++;
      return;
    end
    ax = row_dot(row_x, x, y, z) >>> 7;
    ay = row_dot(row_y, x, y, z) >>> 7;
    qx = ax / dep;
    qy = ay / dep;
    s.sx = 16'(qx + 32'sd160);
    s.sy = 16'(qy + 32'sd100);
    s.pd = dep[15:0];
    screen_q.push_back(s);
  endtask

  // Driver: points leave the pending queue; the prediction is made on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        project_point(point_t'(s_axis_tdata));
        n_points++;
      end
      if ((!s_axis_tvalid || s_axis_tready)) begin
        if (point_q.size() > 0 && ($urandom_range(99) >= src_idle)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= point_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // The long receiver hold-off is counted down here.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        screen_t got, want;
        got = screen_t'(m_axis_tdata);
        n_screens++;
        if (screen_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = screen_q.pop_front();
          if (got.sx !== want.sx) begin
            $display("%0t: screen_x expected %h got %h", $time, want.sx, got.sx);
            errors++;
          end
          if (got.sy !== want.sy) begin
            $display("%0t: screen_y expected %h got %h", $time, want.sy, got.sy);
            errors++;
          end
          if (got.pd !== want.pd) begin
            $display("%0t: point_depth expected %h got %h", $time, want.pd, got.pd);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegCamX: cam_x = val[15:0];
      RegCamY: cam_y = val[15:0];
      RegCamZ: cam_z = val[15:0];
      RegRowX: row_x = val[47:0];
      RegRowY: row_y = val[47:0];
      default: row_d = val[47:0];
    endcase
  endtask

  task automatic drain();
    while (point_q.size() > 0 || s_axis_tvalid || screen_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.px = rand_coord();
    p.py = rand_coord();
    p.pz = rand_coord();
    return p;
  endfunction

  task automatic load_camera(int mode);
    logic [15:0] c[3];
    logic [47:0] rx, ry, rd;
    for (int i = 0; i < 3; i++) begin
      c[i] = (mode == 0) ? 16'h0000 : (mode == 1) ? 16'h8000 :
             (mode == 2) ? 16'h7fff : 16'($urandom);
    end
    rx = (mode == 1) ? 48'h8000_8000_8000 : (mode == 2) ? 48'h7fff_7fff_7fff :
         {16'($urandom), 16'($urandom), 16'($urandom)};
    ry = (mode == 1) ? 48'h7fff_7fff_7fff : (mode == 2) ? 48'h8000_8000_8000 :
         {16'($urandom), 16'($urandom), 16'($urandom)};
    // A mostly forward depth row keeps a fair share of points in front of the camera.
    rd = (mode == 1) ? 48'h8000_8000_8000 : (mode == 2) ? 48'h7fff_0000_0000 :
         {16'($urandom_range(32767, 8000)), 16'($urandom_range(4000)),
          16'($urandom_range(4000))};
    reg_write(RegCamX, {48'h0, c[0]});
    reg_write(RegCamY, {48'h0, c[1]});
    reg_write(RegCamZ, {48'h0, c[2]});
    reg_write(RegRowX, {16'h0, rx});
    reg_write(RegRowY, {16'h0, ry});
    reg_write(RegRowD, {16'h0, rd});
  endtask

  initial begin
    point_t p;
    cam_x = '0; cam_y = '0; cam_z = '0;
    row_x = '0; row_y = '0; row_d = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: zero matrix culls everything, then extremes with a forward depth row.
    point_q.push_back('0);
    point_q.push_back({16'h7fff, 16'h7fff, 16'h7fff});
    drain();
    reg_write(RegRowD, 64'h0000_0000_0000_4000);
    reg_write(RegRowX, 64'h0000_0000_0000_0100);
    reg_write(RegRowY, 64'h0000_0000_ff00_0000);
    reg_write(RegCamX, 64'h8000);
    reg_write(RegCamY, 64'h7fff);
    reg_write(RegCamZ, 64'h0001);
    for (int i = 0; i < 16; i++) begin
      p.px = (i[0]) ? 16'h7fff : 16'h8000;
      p.py = (i[1]) ? 16'h7fff : 16'h8000;
      p.pz = (i[2]) ? 16'hffff : (i[3] ? 16'h0002 : 16'h0000);
      point_q.push_back(p);
    end
    drain();
    // Random phases with different camera settings and idling patterns.
    for (int ph = 0; ph < 12; ph++) begin
      load_camera(ph % 4);
      case (ph % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 86; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 86; end
        default: begin src_idle = 16; sink_stall = 16; end
      endcase
      if (ph == 4) hold_cycles = 200;
      for (int i = 0; i < 95; i++) point_q.push_back(rand_point());
      drain();
    end
    $display("Covered %0d points: %0d results, %0d culled by depth,", n_points, n_screens,
             n_culled);
    $display("over 12 camera settings with random source gaps and sink stalls.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
